// File: design/triangle_lfo_stereo_chorus_assert.svh
// Assertion macros for the stereo chorus block.
// Included by the top level; depends on nothing else.
`ifndef TRIANGLE_LFO_STEREO_CHORUS_ASSERT_SVH
`define TRIANGLE_LFO_STEREO_CHORUS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlsc assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlsc assertion failed");

`endif

// File: design/tlsc_pkg.sv
// Shared types, constants and helpers of the stereo chorus block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tlsc_pkg;

   // Sizes
   localparam int DELAY_LENGTH = 4096;                  // power of two
   localparam int ADDR_W       = $clog2(DELAY_LENGTH);
   localparam int FRAC_W       = 8;                     // Q.8 delay fraction
   localparam int RP_W         = ADDR_W + FRAC_W;       // read position width
   localparam int SAMPLE_W     = 24;
   localparam int PHASE_W      = 24;
   localparam int DELAY_W      = 20;
   localparam int TRI_W        = PHASE_W + 2;           // Q1.24 triangle
   localparam int PROD_W       = DELAY_W + 1 + TRI_W;   // depth * triangle
   localparam int OFF_W        = PROD_W - PHASE_W;      // signed delay offset
   localparam int DLY_W        = OFF_W;                 // signed delay
   localparam int WET_W        = SAMPLE_W + 10;         // interpolated tap, Q.8
   localparam int MIX_W        = WET_W + 1;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;

   localparam int FRAC_ONE     = 1 << FRAC_W;
   localparam int ROUND_OFF    = 1 << (PHASE_W - 1);
   localparam int MIX_ROUND    = 1 << FRAC_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SLOW = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_FAST = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH     = 3'd4;

   // Mode codes
   localparam logic [1:0] MODE_BYPASS = 2'd0;
   localparam logic [1:0] MODE_SLOW   = 2'd1;

   // Register reset values
   localparam logic [PHASE_W-1:0] STEP_SLOW_RST = 24'd187;
   localparam logic [PHASE_W-1:0] STEP_FAST_RST = 24'd315;
   localparam logic [DELAY_W-1:0] CENTRE_RST    = 20'd94618;
   localparam logic [DELAY_W-1:0] DEPTH_RST     = 20'd45466;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADDR,
      S_RD_L,
      S_RD_R,
      S_WET_R,
      S_OUT
   } tlsc_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic calc_addr;
      logic read_left;
      logic wet_left;
      logic wet_right;
      logic load_out;
   } tlsc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bypass_now;
      logic out_free;
   } tlsc_status_type;

   // Triangle of a phase word: rises from -1 to +1 over the first half cycle
   function automatic logic signed [TRI_W-1:0] triangle(input logic [PHASE_W-1:0] p);
      logic [TRI_W:0] four_p;
      logic [TRI_W:0] tri_w;
      four_p = {1'b0, p, 2'b00};
      if (p[PHASE_W-1]) begin
         tri_w = (TRI_W + 1)'(3 << PHASE_W) - four_p;
      end else begin
         tri_w = four_p - (TRI_W + 1)'(1 << PHASE_W);
      end
      return tri_w[TRI_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/tlsc_ctrl.sv
// Sequencing state machine of the stereo chorus block.
// Depends on tlsc_pkg; drives the datapath through tlsc_cmd_type.
`default_nettype none

module tlsc_ctrl
   import tlsc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire tlsc_status_type status,
   output      tlsc_cmd_type    cmd
);

   tlsc_state_type state_ff;
   tlsc_state_type state_in;
   logic           take;

   // Accept only when idle and out of reset
   assign req_stall = reset || (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = status.bypass_now ? S_OUT : S_ADDR;
            end
         end
         S_ADDR:  state_in = S_RD_L;
         S_RD_L:  state_in = S_RD_R;
         S_RD_R:  state_in = S_WET_R;
         S_WET_R: state_in = S_OUT;
         S_OUT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:  cmd.accept    = take;
         S_ADDR:  cmd.calc_addr = 1'b1;
         S_RD_L:  cmd.read_left = 1'b1;
         S_RD_R:  cmd.wet_left  = 1'b1;
         S_WET_R: cmd.wet_right = 1'b1;
         S_OUT:   cmd.load_out  = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tlsc_datapath.sv
// Datapath of the stereo chorus: registers, LFO, delay store, taps and mix.
// Depends on tlsc_pkg; commanded by tlsc_ctrl.
`default_nettype none

module tlsc_datapath
   import tlsc_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tlsc_cmd_type                  cmd,
   output      tlsc_status_type               status,
   input  wire logic signed [SAMPLE_W-1:0]    req_sample_in,
   input  wire logic                          csr_write,
   input  wire logic        [CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [CSR_DATA_W-1:0]  csr_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [SAMPLE_W-1:0]    rsp_left_out,
   output      logic signed [SAMPLE_W-1:0]    rsp_right_out
);

   // Configuration
   logic [1:0]         mode_ff;
   logic [PHASE_W-1:0] step_slow_ff;
   logic [PHASE_W-1:0] step_fast_ff;
   logic [DELAY_W-1:0] centre_ff;
   logic [DELAY_W-1:0] depth_ff;

   // Running state
   logic [ADDR_W-1:0]  wp_ff;
   logic               wrapped_ff;
   logic [PHASE_W-1:0] phase_ff;

   // Item registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       bypass_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic [ADDR_W-1:0]          addr_l0_ff, addr_l1_ff, addr_r0_ff, addr_r1_ff;
   logic [FRAC_W-1:0]          fr_l_ff, fr_r_ff;
   logic                       ok_l0_ff, ok_l1_ff, ok_r0_ff, ok_r1_ff;
   logic signed [SAMPLE_W-1:0] rd0_ff, rd1_ff;
   logic signed [WET_W-1:0]    wet_l_ff, wet_r_ff;
   logic signed [WET_W-1:0]    wet_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;

   // Delay store
   logic [SAMPLE_W-1:0] mem [DELAY_LENGTH];

   logic signed [TRI_W-1:0]    tri_w;
   logic signed [PROD_W-1:0]   sum_l, sum_r;
   logic signed [DLY_W-1:0]    delay_l, delay_r;
   logic [RP_W-1:0]            rp_l, rp_r;
   logic [ADDR_W-1:0]          a_l0, a_l1, a_r0, a_r1;
   logic [ADDR_W-1:0]          rd_addr0, rd_addr1;
   logic [FRAC_W-1:0]          fr_sel;
   logic [FRAC_W:0]            fr_inv;
   logic                       ok0_sel, ok1_sel;
   logic signed [SAMPLE_W-1:0] s0, s1;
   logic signed [MIX_W-1:0]    mix_l, mix_r;
   logic [PHASE_W-1:0]         step_sel;

   assign status.bypass_now = (mode_ff == MODE_BYPASS);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BYPASS;
         step_slow_ff <= STEP_SLOW_RST;
         step_fast_ff <= STEP_FAST_RST;
         centre_ff    <= CENTRE_RST;
         depth_ff     <= DEPTH_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:      mode_ff      <= csr_data[1:0];
            CSR_STEP_SLOW: step_slow_ff <= csr_data[PHASE_W-1:0];
            CSR_STEP_FAST: step_fast_ff <= csr_data[PHASE_W-1:0];
            CSR_CENTRE:    centre_ff    <= csr_data[DELAY_W-1:0];
            CSR_DEPTH:     depth_ff     <= csr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // LFO swing times depth; the right channel's triangle is the negation
   assign tri_w   = triangle(phase_ff);
   assign prod_in = PROD_W'($signed({1'b0, depth_ff})) * PROD_W'(tri_w);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample_in;
         bypass_ff <= (mode_ff == MODE_BYPASS);
         prod_ff   <= prod_in;
      end
   end

   // Store the sample first, so a zero delay reads it back
   always_ff @(posedge clock) begin
      if (cmd.accept && (mode_ff != MODE_BYPASS)) begin
         mem[wp_ff] <= req_sample_in;
      end
   end

   // Delays and tap addresses
   assign sum_l   = prod_ff + PROD_W'(ROUND_OFF);
   assign sum_r   = PROD_W'(ROUND_OFF) - prod_ff;
   assign delay_l = $signed({{(DLY_W - DELAY_W){1'b0}}, centre_ff}) + sum_l[PROD_W-1:PHASE_W];
   assign delay_r = $signed({{(DLY_W - DELAY_W){1'b0}}, centre_ff}) + sum_r[PROD_W-1:PHASE_W];
   assign rp_l    = {wp_ff, {FRAC_W{1'b0}}} - RP_W'(delay_l);
   assign rp_r    = {wp_ff, {FRAC_W{1'b0}}} - RP_W'(delay_r);
   assign a_l0    = rp_l[RP_W-1:FRAC_W];
   assign a_l1    = a_l0 + ADDR_W'(1);
   assign a_r0    = rp_r[RP_W-1:FRAC_W];
   assign a_r1    = a_r0 + ADDR_W'(1);

   // A tap is written once the store has wrapped or it lies at or behind the write point
   always_ff @(posedge clock) begin
      if (cmd.calc_addr) begin
         addr_l0_ff <= a_l0;
         addr_l1_ff <= a_l1;
         addr_r0_ff <= a_r0;
         addr_r1_ff <= a_r1;
         fr_l_ff    <= rp_l[FRAC_W-1:0];
         fr_r_ff    <= rp_r[FRAC_W-1:0];
         ok_l0_ff   <= wrapped_ff || (a_l0 <= wp_ff);
         ok_l1_ff   <= wrapped_ff || (a_l1 <= wp_ff);
         ok_r0_ff   <= wrapped_ff || (a_r0 <= wp_ff);
         ok_r1_ff   <= wrapped_ff || (a_r1 <= wp_ff);
      end
   end

   // Read one channel's tap pair per cycle
   assign rd_addr0 = cmd.read_left ? addr_l0_ff : addr_r0_ff;
   assign rd_addr1 = cmd.read_left ? addr_l1_ff : addr_r1_ff;

   always_ff @(posedge clock) begin
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   // Interpolate between the two taps
   assign fr_sel  = cmd.wet_left ? fr_l_ff : fr_r_ff;
   assign ok0_sel = cmd.wet_left ? ok_l0_ff : ok_r0_ff;
   assign ok1_sel = cmd.wet_left ? ok_l1_ff : ok_r1_ff;
   assign s0      = ok0_sel ? rd0_ff : '0;
   assign s1      = ok1_sel ? rd1_ff : '0;
   assign fr_inv  = (FRAC_W + 1)'(FRAC_ONE) - {1'b0, fr_sel};
   assign wet_in  = WET_W'(s0) * WET_W'($signed({1'b0, fr_inv}))
                    + WET_W'(s1) * WET_W'($signed({2'b00, fr_sel}));

   always_ff @(posedge clock) begin
      if (cmd.wet_left) begin
         wet_l_ff <= wet_in;
      end
      if (cmd.wet_right) begin
         wet_r_ff <= wet_in;
      end
   end

   // Mix dry and wet halves with rounding
   assign mix_l = MIX_W'($signed({sample_ff, {FRAC_W{1'b0}}})) + MIX_W'(wet_l_ff)
                  + MIX_W'(MIX_ROUND);
   assign mix_r = MIX_W'($signed({sample_ff, {FRAC_W{1'b0}}})) + MIX_W'(wet_r_ff)
                  + MIX_W'(MIX_ROUND);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (bypass_ff) begin
            left_ff  <= sample_ff;
            right_ff <= sample_ff;
         end else begin
            left_ff  <= mix_l[SAMPLE_W+FRAC_W:FRAC_W+1];
            right_ff <= mix_r[SAMPLE_W+FRAC_W:FRAC_W+1];
         end
      end
   end

   // Output register valid: set on load, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Advance write point and LFO after each chorus item
   assign step_sel = (mode_ff == MODE_SLOW) ? step_slow_ff : step_fast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         phase_ff   <= '0;
      end else if (cmd.load_out && !bypass_ff) begin
         wp_ff    <= wp_ff + ADDR_W'(1);
         phase_ff <= phase_ff + step_sel;
         if (wp_ff == ADDR_W'(DELAY_LENGTH - 1)) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

`default_nettype wire

// File: design/triangle_lfo_stereo_chorus.sv
// Stereo chorus, top level: one mono sample in, one left/right pair out.
// Depends on tlsc_pkg, tlsc_ctrl, tlsc_datapath and the assertion macro header.
//
// A chorus item goes through these steps from transfer to the next possible
// transfer: take the sample, write the store and form depth times triangle;
// form the tap addresses; read the two-port store, one channel's tap pair at
// a time; interpolate the right taps; then mix and load the output register,
// a load that waits while that register holds a stalled pair. A bypass item
// (mode 0) goes from taking the sample straight to loading the output register.
// A finished pair waits in the output register while the next sample is taken.
// The store needs no clearing pass: a fill tracker makes taps not yet written
// since reset read as zero, so the block takes samples right after reset.
// Configuration writes are always ready and must be made while the block is idle.
`default_nettype none

module triangle_lfo_stereo_chorus
   import tlsc_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_W-1:0]    req_sample_in,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [SAMPLE_W-1:0]    rsp_left_out,
   output      logic signed [SAMPLE_W-1:0]    rsp_right_out,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic        [CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [CSR_DATA_W-1:0]  csr_data
);

   tlsc_cmd_type    cmd;
   tlsc_status_type status;

   assign csr_ready = 1'b1;

   tlsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlsc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample_in (req_sample_in),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   // Checks
`include "triangle_lfo_stereo_chorus_assert.svh"

   `TLSC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   `TLSC_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_out, !rsp_valid || !rsp_stall)
   `TLSC_ASSERT_NOW(a_valid_from_load, clock, reset, $rose(rsp_valid), $past(cmd.load_out))

endmodule

`default_nettype wire

// File: tb/tb_triangle_lfo_stereo_chorus.sv
// Self-checking testbench for the stereo chorus: directed table, then random phases.
// Holds its own bit-exact model of the chorus; depends on tlsc_pkg and the top level only.
`default_nettype none

module tb_triangle_lfo_stereo_chorus;
   import tlsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 50;
   localparam int RANDOM_PHASES = 11;
   localparam int PAUSE_PHASE   = 2;

   localparam logic [1:0] MODE_FAST = 2'd2;
   localparam logic [1:0] MODE_ALT  = 2'd3;   // undefined code, runs as fast chorus

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd5;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_pair_type;

   typedef struct packed {
      logic                       is_csr;
      logic [CSR_INDEX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       known;
      stereo_pair_type            pair;
   } stim_row_type;

   // DUT ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_W-1:0]    req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_left_out;
   logic signed [SAMPLE_W-1:0]    rsp_right_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic        [CSR_INDEX_W-1:0] csr_index = '0;
   logic        [CSR_DATA_W-1:0]  csr_data = '0;

   // Model state and registers
   logic signed [SAMPLE_W-1:0] echo_mem [DELAY_LENGTH];
   logic [ADDR_W-1:0]          head_pos;
   logic [PHASE_W-1:0]         sweep_phase;
   logic [1:0]                 mode_reg;
   logic [PHASE_W-1:0]         slow_step_reg;
   logic [PHASE_W-1:0]         fast_step_reg;
   logic [DELAY_W-1:0]         centre_reg;
   logic [DELAY_W-1:0]         depth_reg;

   stereo_pair_type pending_pairs[$];
   stim_row_type    directed_rows[$];

   logic idling_on = 1'b1;
   int   stall_left = 0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   samples_sent = 0;
   int   pairs_checked = 0;
   int   csr_writes = 0;
   int   chorus_items = 0;

   triangle_lfo_stereo_chorus uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Triangle sweep in Q1.24: rises over the first half cycle, falls over the second
   function automatic longint sweep_shape(input logic [PHASE_W-1:0] p);
      if (p < 24'h800000) begin
         return 4 * longint'(p) - (longint'(1) <<< 24);
      end
      return 3 * (longint'(1) <<< 24) - 4 * longint'(p);
   endfunction

   // Modulated delay in signed Q14.8, rounded offset
   function automatic longint tap_delay_q8(input longint shape);
      return longint'(centre_reg) + ((longint'(depth_reg) * shape + 64'sd8388608) >>> 24);
   endfunction

   // Interpolated wet tap, Q.8 above sample scale; read position wraps on the store
   function automatic longint wet_tap(input longint dly);
      logic [RP_W-1:0]   rpos;
      logic [ADDR_W-1:0] near_idx;
      logic [ADDR_W-1:0] far_idx;
      longint            frac;
      rpos     = RP_W'(longint'(head_pos) * 256 - dly);
      near_idx = rpos[RP_W-1:FRAC_W];
      far_idx  = near_idx + ADDR_W'(1);
      frac     = longint'(rpos[FRAC_W-1:0]);
      return longint'(echo_mem[near_idx]) * (256 - frac) + longint'(echo_mem[far_idx]) * frac;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] dry_wet_mix(
      input logic signed [SAMPLE_W-1:0] dry, input longint wet);
      longint acc;
      acc = longint'(dry) * 256 + wet + 256;
      return SAMPLE_W'(acc >>> 9);
   endfunction

   // Advance the model by one sample and return the stereo pair it gives
   function automatic stereo_pair_type chorus_pair(input logic signed [SAMPLE_W-1:0] s);
      stereo_pair_type pr;
      logic [PHASE_W-1:0] opp_phase;
      if (mode_reg == MODE_BYPASS) begin
         pr.left  = s;
         pr.right = s;
         return pr;
      end
      echo_mem[head_pos] = s;
      opp_phase = sweep_phase + 24'h800000;
      pr.left   = dry_wet_mix(s, wet_tap(tap_delay_q8(sweep_shape(sweep_phase))));
      pr.right  = dry_wet_mix(s, wet_tap(tap_delay_q8(sweep_shape(opp_phase))));
      head_pos  = head_pos + ADDR_W'(1);
      sweep_phase = sweep_phase + ((mode_reg == MODE_SLOW) ? slow_step_reg : fast_step_reg);
      return pr;
   endfunction

   function automatic void model_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_MODE:      mode_reg      = d[1:0];
         CSR_STEP_SLOW: slow_step_reg = d[PHASE_W-1:0];
         CSR_STEP_FAST: fast_step_reg = d[PHASE_W-1:0];
         CSR_CENTRE:    centre_reg    = d[DELAY_W-1:0];
         CSR_DEPTH:     depth_reg     = d[DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Present one sample, hold it until transfer, then queue its expected pair.
   // Valid stays high on return; the caller sends again or lowers it in this step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic known,
                              input stereo_pair_type typed);
      stereo_pair_type pr;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode_reg != MODE_BYPASS) chorus_items++;
      pr = chorus_pair(s);
      pending_pairs.push_back(known ? typed : pr);
      samples_sent++;
   endtask

   // Drop valid and hold until every pair is back and the pipeline has emptied
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Valid stays high on return; the caller writes again or lowers it in this step
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_reg_write(idx, d);
      csr_writes++;
   endtask

   function automatic void add_csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] d);
      stim_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.index  = idx;
      row.data   = d;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_sample_row(input logic [SAMPLE_W-1:0] s, input logic known,
                                          input logic [SAMPLE_W-1:0] l,
                                          input logic [SAMPLE_W-1:0] r);
      stim_row_type row;
      row            = '0;
      row.sample     = s;
      row.known      = known;
      row.pair.left  = l;
      row.pair.right = r;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_step();
      case ($urandom_range(0, 3))
         0:       return CSR_DATA_W'($urandom_range(0, 4095));
         1:       return CSR_DATA_W'($urandom);
         2:       return '0;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   // Delay register value; upper bits are junk to exercise masking
   function automatic logic [CSR_DATA_W-1:0] random_delay(input int typical_max);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0:       d[DELAY_W-1:0] = '0;
         1:       d[DELAY_W-1:0] = 20'hFFFFF;
         2:       ;
         default: d[DELAY_W-1:0] = DELAY_W'($urandom_range(0, typical_max));
      endcase
      return d;
   endfunction

   task automatic random_config();
      logic [CSR_DATA_W-1:0] d;
      int                    pick;
      pick = $urandom_range(0, 9);
      d = CSR_DATA_W'($urandom);
      if (pick == 0)      d[1:0] = MODE_BYPASS;
      else if (pick <= 4) d[1:0] = MODE_SLOW;
      else if (pick <= 8) d[1:0] = MODE_FAST;
      else                d[1:0] = MODE_ALT;
      csr_write(CSR_MODE, d);
      csr_write(CSR_STEP_SLOW, random_step());
      csr_write(CSR_STEP_FAST, random_step());
      csr_write(CSR_CENTRE, random_delay(300 * FRAC_ONE));
      csr_write(CSR_DEPTH, random_delay(200 * FRAC_ONE));
      if ($urandom_range(0, 2) == 0) begin
         csr_write(CSR_UNUSED_FIRST + CSR_INDEX_W'($urandom_range(0, 2)), CSR_DATA_W'($urandom));
      end
   endtask

   // Check each transferred pair against the oldest expectation
   always @(posedge clock) begin
      stereo_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch($sformatf("unexpected pair L=%0d R=%0d", rsp_left_out,
                                      rsp_right_out));
         end else begin
            want = pending_pairs.pop_front();
            pairs_checked++;
            if (rsp_left_out !== want.left) begin
               report_mismatch($sformatf("left_out got %0d want %0d", rsp_left_out,
                                         want.left));
            end
            if (rsp_right_out !== want.right) begin
               report_mismatch($sformatf("right_out got %0d want %0d", rsp_right_out,
                                         want.right));
            end
         end
      end
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] run timed out", $realtime);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type    row;
      stereo_pair_type none;
      logic            csr_open;
      int              ph;
      int              k;

      // Model reset
      foreach (echo_mem[i]) echo_mem[i] = '0;
      head_pos      = '0;
      sweep_phase   = '0;
      mode_reg      = MODE_BYPASS;
      slow_step_reg = STEP_SLOW_RST;
      fast_step_reg = STEP_FAST_RST;
      centre_reg    = CENTRE_RST;
      depth_reg     = DEPTH_RST;
      none          = '0;
      csr_open      = 1'b0;

      // Bypass after reset: both outputs echo the input
      add_sample_row(24'h7FFFFF, 1'b1, 24'h7FFFFF, 24'h7FFFFF);
      add_sample_row(24'h800000, 1'b1, 24'h800000, 24'h800000);
      add_sample_row(24'h000000, 1'b1, 24'h000000, 24'h000000);
      add_sample_row(24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
      add_sample_row(24'h555555, 1'b1, 24'h555555, 24'h555555);
      add_sample_row(24'hAAAAAA, 1'b1, 24'hAAAAAA, 24'hAAAAAA);
      // First chorus samples see an empty store: out is half the dry sample
      add_csr_row(CSR_MODE, 24'h000001);
      add_sample_row(24'h7FFFFF, 1'b1, 24'h400000, 24'h400000);
      add_sample_row(24'h800000, 1'b1, 24'hC00000, 24'hC00000);
      add_sample_row(24'h3FFFFF, 1'b0, '0, '0);
      add_sample_row(24'hC00001, 1'b0, '0, '0);
      add_sample_row(24'h000001, 1'b0, '0, '0);
      // Zero delay reads the sample just written, so out equals in
      add_csr_row(CSR_CENTRE, 24'h000000);
      add_csr_row(CSR_DEPTH, 24'h000000);
      add_sample_row(24'h123456, 1'b1, 24'h123456, 24'h123456);
      add_sample_row(24'hEDCBA9, 1'b1, 24'hEDCBA9, 24'hEDCBA9);
      // Undefined mode code, largest fast step, zero slow step and delays beyond the store
      add_csr_row(CSR_MODE, 24'hFFFFFF);
      add_csr_row(CSR_STEP_FAST, 24'hFFFFFF);
      add_csr_row(CSR_STEP_SLOW, 24'h000000);
      add_csr_row(CSR_CENTRE, 24'h0FFFFF);
      add_csr_row(CSR_DEPTH, 24'h0FFFFF);
      add_sample_row(24'h7FFFFF, 1'b0, '0, '0);
      add_sample_row(24'h800000, 1'b0, '0, '0);
      add_sample_row(24'h2468AC, 1'b0, '0, '0);
      // Negative delays: zero centre with full depth, masked mode write
      add_csr_row(CSR_MODE, 24'hFFFFFE);
      add_csr_row(CSR_CENTRE, 24'h000000);
      add_csr_row(CSR_STEP_FAST, 24'h400000);
      add_sample_row(24'h654321, 1'b0, '0, '0);
      add_sample_row(24'h9ABCDE, 1'b0, '0, '0);
      add_sample_row(24'h0F0F0F, 1'b0, '0, '0);
      // Unused indexes, zero step, fractional centre with junk upper bits
      add_csr_row(CSR_UNUSED_FIRST, 24'hFFFFFF);
      add_csr_row(CSR_UNUSED_FIRST + 3'd1, 24'hFFFFFF);
      add_csr_row(CSR_UNUSED_FIRST + 3'd2, 24'hFFFFFF);
      add_csr_row(CSR_MODE, 24'h000001);
      add_csr_row(CSR_CENTRE, 24'hF00140);
      add_csr_row(CSR_DEPTH, 24'h000000);
      add_sample_row(24'h700000, 1'b0, '0, '0);
      add_sample_row(24'h8FFFFF, 1'b0, '0, '0);
      add_sample_row(24'h00FF00, 1'b0, '0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; register writes only with the block drained
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            if (!csr_open) begin
               drain_block();
               csr_open = 1'b1;
            end
            csr_write(row.index, row.data);
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_sample(row.sample, row.known, row.pair);
         end
      end

      // Random phases, each under a fresh register setting; the last one runs without gaps
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_block();
         if (ph == RANDOM_PHASES - 1) idling_on <= 1'b0;
         random_config();
         csr_valid <= 1'b0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (pending_pairs.size() != 0) @(posedge clock);
            end
            send_sample(SAMPLE_W'($urandom), 1'b0, none);
         end
      end

      // Wait for the tail, then keep watching for strays
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (pending_pairs.size() != 0) begin
         report_mismatch($sformatf("%0d pairs never arrived", pending_pairs.size()));
      end

      $display("Ran %0d samples (%0d through the chorus path), checked %0d stereo pairs,",
               samples_sent, chorus_items, pairs_checked);
      $display("over %0d register writes in %0d random settings; %0d mismatches.",
               csr_writes, RANDOM_PHASES, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
